[rtl/core/two_digit_seven_segment_shift_driver_unit_macros.svh]
// Assertion macros used by the driver's sequencer RTL (segdrv_seq).
`ifndef TWO_DIGIT_SEVEN_SEGMENT_SHIFT_DRIVER_UNIT_MACROS_SVH
`define TWO_DIGIT_SEVEN_SEGMENT_SHIFT_DRIVER_UNIT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define SEGDRV_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define SEGDRV_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

[rtl/core/segdrv_pkg.sv]
package segdrv_pkg;

  localparam int IMAGE_BITS = 16;
  localparam int IDX_W      = $clog2(IMAGE_BITS);
  localparam int NUM_W      = 15;
  localparam int QUO_W      = 9;
  localparam int REM_W      = 7;
  localparam int DIGIT_W    = 4;
  localparam int GLYPH_W    = 8;

  // Decimal radix constants and their reciprocal multipliers.
  localparam int DEC_HUNDRED = 100;
  localparam int DEC_TEN     = 10;
  localparam int DIV100_MUL  = 5243;
  localparam int DIV100_SH   = 19;
  localparam int DIV10_MUL   = 205;
  localparam int DIV10_SH    = 11;

  localparam int OP_CLEAR = 1;

  typedef logic [3:0] step_t;

  localparam step_t STEP_IDLE     = 4'd0;
  localparam step_t STEP_QUO      = 4'd1;
  localparam step_t STEP_REM      = 4'd2;
  localparam step_t STEP_TENS     = 4'd3;
  localparam step_t STEP_IMG      = 4'd4;
  localparam step_t STEP_LATCH_LO = 4'd5;
  localparam step_t STEP_SCLK_LO  = 4'd6;
  localparam step_t STEP_DATA     = 4'd7;
  localparam step_t STEP_SCLK_HI  = 4'd8;
  localparam step_t STEP_LATCH_HI = 4'd9;

  typedef enum logic [2:0] {
    PIN_NONE,
    PIN_LATCH_LO,
    PIN_SCLK_LO,
    PIN_DATA,
    PIN_SCLK_HI,
    PIN_LATCH_HI
  } pin_op_t;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_WAIT_IN,
    JMP_LOOP,
    JMP_GOTO
  } jmp_t;

  typedef struct packed {
    logic    accept;
    logic    load_q;
    logic    load_r;
    logic    load_t;
    logic    load_img;
    logic    set_bits;
    logic    emit;
    logic    last;
    pin_op_t pin_op;
    jmp_t    jmp;
    step_t   target;
  } uword_t;

  typedef struct packed {
    logic             take;
    logic             load_q;
    logic             load_r;
    logic             load_t;
    logic             load_img;
    logic             fire;
    logic             last;
    pin_op_t          pin_op;
    logic [IDX_W-1:0] bit_idx;
  } ctrl_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

  // Segment pattern, bit i = segment i (a..g, dp).
  function automatic logic [GLYPH_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
    logic [GLYPH_W-1:0] g;
    case (d)
      4'd0:    g = 8'h3F;
      4'd1:    g = 8'h06;
      4'd2:    g = 8'h5B;
      4'd3:    g = 8'h4F;
      4'd4:    g = 8'h66;
      4'd5:    g = 8'h6D;
      4'd6:    g = 8'h7D;
      4'd7:    g = 8'h07;
      4'd8:    g = 8'h7F;
      4'd9:    g = 8'h67;
      default: g = '0;
    endcase
    return g;
  endfunction

  // Microcode program.
  function automatic uword_t ucode(input step_t s);
    uword_t w;
    w = '{default: '0, pin_op: PIN_NONE, jmp: JMP_NEXT, target: STEP_IDLE};
    case (s)
      STEP_IDLE: begin
        w.accept = 1'b1;
        w.jmp    = JMP_WAIT_IN;
      end
      STEP_QUO:  w.load_q = 1'b1;
      STEP_REM:  w.load_r = 1'b1;
      STEP_TENS: w.load_t = 1'b1;
      STEP_IMG: begin
        w.load_img = 1'b1;
        w.set_bits = 1'b1;
      end
      STEP_LATCH_LO: begin
        w.emit   = 1'b1;
        w.pin_op = PIN_LATCH_LO;
      end
      STEP_SCLK_LO: begin
        w.emit   = 1'b1;
        w.pin_op = PIN_SCLK_LO;
      end
      STEP_DATA: begin
        w.emit   = 1'b1;
        w.pin_op = PIN_DATA;
      end
      STEP_SCLK_HI: begin
        w.emit   = 1'b1;
        w.pin_op = PIN_SCLK_HI;
        w.jmp    = JMP_LOOP;
        w.target = STEP_SCLK_LO;
      end
      STEP_LATCH_HI: begin
        w.emit   = 1'b1;
        w.last   = 1'b1;
        w.pin_op = PIN_LATCH_HI;
        w.jmp    = JMP_GOTO;
        w.target = STEP_IDLE;
      end
      default: begin
        w.jmp    = JMP_GOTO;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

[rtl/core/two_digit_seven_segment_shift_driver_unit.sv]
// Two-digit seven-segment driver for an external serial-in, latched-out
// shift register.
// Input channel (in_valid / in_stall): one request per transaction. operation
// 0 draws the last two decimal digits of number; operation 1 clears the
// display. Output channel (out_valid / out_stall): one transaction per pin
// write, giving the serial_data, shift_clock and latch_clock levels after
// that write; last marks the final write (latch high).
// Each request yields 50 transactions: latch low, then for image bit 15
// down to 0 clock low, data, clock high, then latch high.
// Sequence: a request is taken only while the microcode sits at its idle
// step. Four steps follow (quotient, remainder, tens digit, image load),
// then one step per pin write.
// A stalled output holds its transaction; the sequencer holds its step
// until the slot frees. Reset returns the program to idle, drives all pins
// low and empties the output register.
module two_digit_seven_segment_shift_driver_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         operation,
  input  logic [segdrv_pkg::NUM_W-1:0] number,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         serial_data,
  output logic                         shift_clock,
  output logic                         latch_clock,
  output logic                         last
);
  import segdrv_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  // Microcode step counter, bit counter and jump logic
  segdrv_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  // Digit split, segment image, pin levels and output register
  segdrv_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .operation   (operation),
    .number      (number),
    .ctrl        (ctrl),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .serial_data (serial_data),
    .shift_clock (shift_clock),
    .latch_clock (latch_clock),
    .last        (last)
  );

endmodule

[rtl/core/segdrv_seq.sv]
`include "two_digit_seven_segment_shift_driver_unit_macros.svh"

module segdrv_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  segdrv_pkg::stat_t stat,
  output segdrv_pkg::ctrl_t ctrl
);
  import segdrv_pkg::*;

  step_t            pc, pc_next;
  logic [IDX_W-1:0] bits, bits_next;
  uword_t           uw;
  logic             advance;

  assign uw       = ucode(pc);
  assign in_stall = !uw.accept;
  assign advance  = !uw.emit || stat.out_free;

  always_comb begin
    ctrl.take     = uw.accept && in_valid;
    ctrl.load_q   = uw.load_q;
    ctrl.load_r   = uw.load_r;
    ctrl.load_t   = uw.load_t;
    ctrl.load_img = uw.load_img;
    ctrl.fire     = uw.emit && stat.out_free;
    ctrl.last     = uw.last;
    ctrl.pin_op   = uw.pin_op;
    ctrl.bit_idx  = bits;
  end

  always_comb begin
    pc_next   = pc;
    bits_next = bits;
    if (uw.set_bits) begin
      bits_next = IDX_W'(IMAGE_BITS - 1);
    end
    if (advance) begin
      case (uw.jmp)
        JMP_NEXT: pc_next = pc + step_t'(1);
        JMP_WAIT_IN: begin
          if (in_valid) begin
            pc_next = pc + step_t'(1);
          end
        end
        JMP_LOOP: begin
          if (bits != '0) begin
            bits_next = bits - IDX_W'(1);
            pc_next   = uw.target;
          end else begin
            pc_next = pc + step_t'(1);
          end
        end
        JMP_GOTO: pc_next = uw.target;
        default:  pc_next = STEP_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc   <= STEP_IDLE;
      bits <= '0;
    end else begin
      pc   <= pc_next;
      bits <= bits_next;
    end
  end

  `SEGDRV_ASSERT(a_take_starts, clk, rst, (in_valid && !in_stall) |=> (pc == STEP_QUO), "accepted request did not start the program")
  `SEGDRV_ASSERT(a_emit_hold, clk, rst, (uw.emit && !stat.out_free) |=> $stable(pc) && $stable(bits), "sequencer moved while output was blocked")
  `SEGDRV_ASSERT(a_end_idle, clk, rst, (pc == STEP_LATCH_HI && stat.out_free) |=> (pc == STEP_IDLE), "program did not return to idle after latch high")

endmodule

[rtl/core/segdrv_dp.sv]
module segdrv_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            operation,
  input  logic [segdrv_pkg::NUM_W-1:0]    number,
  input  segdrv_pkg::ctrl_t               ctrl,
  output segdrv_pkg::stat_t               stat,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            serial_data,
  output logic                            shift_clock,
  output logic                            latch_clock,
  output logic                            last
);
  import segdrv_pkg::*;

  logic                  op_r;
  logic [NUM_W-1:0]      num_r;
  logic [QUO_W-1:0]      quo;
  logic [REM_W-1:0]      rem;
  logic [DIGIT_W-1:0]    tens;
  logic [IMAGE_BITS-1:0] image;
  logic [2:0]            pins, pins_next;
  logic                  last_r;

  logic [27:0]           quo_prod;
  logic [27:0]           quo_shift;
  logic [NUM_W-1:0]      rem_full;
  logic [14:0]           tens_prod;
  logic [14:0]           tens_shift;
  logic [REM_W-1:0]      ones_full;

  // num / 100 by reciprocal, exact over the 15-bit range
  assign quo_prod   = 28'(num_r) * 28'(DIV100_MUL);
  assign quo_shift  = quo_prod >> DIV100_SH;
  assign rem_full   = num_r - NUM_W'(NUM_W'(quo) * NUM_W'(DEC_HUNDRED));
  // rem / 10 by reciprocal, exact below 100
  assign tens_prod  = 15'(rem) * 15'(DIV10_MUL);
  assign tens_shift = tens_prod >> DIV10_SH;
  assign ones_full  = rem - REM_W'(REM_W'(tens) * REM_W'(DEC_TEN));

  assign stat.out_free = !out_valid || !out_stall;

  always_comb begin
    pins_next = pins;
    case (ctrl.pin_op)
      PIN_LATCH_LO: pins_next[2] = 1'b0;
      PIN_SCLK_LO:  pins_next[1] = 1'b0;
      PIN_DATA:     pins_next[0] = image[ctrl.bit_idx];
      PIN_SCLK_HI:  pins_next[1] = 1'b1;
      PIN_LATCH_HI: pins_next[2] = 1'b1;
      default:      pins_next = pins;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.take) begin
      op_r  <= operation;
      num_r <= number;
    end
    if (ctrl.load_q) begin
      quo <= quo_shift[QUO_W-1:0];
    end
    if (ctrl.load_r) begin
      rem <= rem_full[REM_W-1:0];
    end
    if (ctrl.load_t) begin
      tens <= tens_shift[DIGIT_W-1:0];
    end
    if (ctrl.load_img) begin
      if (op_r == 1'(OP_CLEAR)) begin
        image <= '0;
      end else begin
        image <= {glyph(ones_full[DIGIT_W-1:0]), glyph(tens)};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pins      <= '0;
      out_valid <= 1'b0;
      last_r    <= 1'b0;
    end else begin
      if (ctrl.fire) begin
        pins      <= pins_next;
        last_r    <= ctrl.last;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign serial_data = pins[0];
  assign shift_clock = pins[1];
  assign latch_clock = pins[2];
  assign last        = last_r;

endmodule
